// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is asserted
`define PT5_ASSERT_RST(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");

// Concurrent assertion that is checked at every edge, also during reset
`define PT5_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("%m: assertion failed");

`endif

// ----- src/pt5_pkg.sv -----
// ---------------------------------------------------------------------------
// pt5_pkg
// Types, character tables and lookup for the packed 5-bit text decoder.
// ---------------------------------------------------------------------------
package pt5_pkg;

	localparam int unsigned WordW  = 16;
	localparam int unsigned CodeW  = 5;
	localparam int unsigned CharW  = 7;
	localparam int unsigned MaxRes = 4;
	localparam int unsigned CntW   = 3;

	localparam logic [CodeW-1:0] CodeToggle = 5'd31;

	// Character set tables, code 0 at the left; the last position pads code 31,
	// which toggles the set and never reads the table.
	localparam logic [255:0] Set0Chars = " abcdefghijklmnopqrstuvwxyz?:'!#";
	localparam logic [255:0] Set1Chars = " 0123456789abcdefghilmnorstuwy-#";

	typedef logic [WordW-1:0] word_t;
	typedef logic [CodeW-1:0] code_t;
	typedef logic [CharW-1:0] char_t;
	typedef logic [CntW-1:0]  cnt_t;

	typedef struct packed {
		char_t character;
		logic  last;
	} res_t;

	typedef struct packed {
		res_t [MaxRes-1:0] ent;
		cnt_t              cnt;
	} dec_t;

	function automatic char_t lookup(input logic set, input code_t code);
		logic [7:0] idx;
		logic [7:0] byte_v;
		idx = {~code, 3'b000};
		if (set) begin
			byte_v = Set1Chars[idx +: 8];
		end else begin
			byte_v = Set0Chars[idx +: 8];
		end
		return byte_v[CharW-1:0];
	endfunction

endpackage

// ----- src/pt5_word_if.sv -----
// ---------------------------------------------------------------------------
// pt5_word_if
// Valid/ready channel carrying one packed 16-bit text word.
// ---------------------------------------------------------------------------
interface pt5_word_if;
	import pt5_pkg::*;

	logic  valid;
	logic  ready;
	word_t packed_word;

	modport source (output valid, output packed_word, input ready);
	modport sink (input valid, input packed_word, output ready);
endinterface

// ----- src/pt5_char_if.sv -----
// ---------------------------------------------------------------------------
// pt5_char_if
// Valid/ready channel carrying one decoded character and its end mark.
// ---------------------------------------------------------------------------
interface pt5_char_if;
	import pt5_pkg::*;

	logic  valid;
	logic  ready;
	char_t character;
	logic  last;

	modport source (output valid, output character, output last, input ready);
	modport sink (input valid, input character, input last, output ready);
endinterface

// ----- src/packed_5bit_text_decoder.sv -----
// ---------------------------------------------------------------------------
// packed_5bit_text_decoder
// Decodes packed words of three 5-bit codes into a stream of ASCII characters.
// ---------------------------------------------------------------------------
//  channel  dir  payload                        handshake
//  words    in   packed_word[15:0]              valid/ready
//  chars    out  character[6:0], last           valid/ready
//
// A word is held in the input register, then loads into the result
// register; it leaves as 0 to 4 characters, one per cycle while chars is
// ready, and the next word loads in the cycle the last character is taken.
// Reset clears the character set to the first set and empties both stages.
// A stall on chars backs up into the input register and then into words.
// ---------------------------------------------------------------------------
module packed_5bit_text_decoder (
	input  logic       clk,
	input  logic       arst_n,
	pt5_word_if.sink   words,
	pt5_char_if.source chars
);
	import pt5_pkg::*;

	logic  valid_s1;
	word_t word_s1;
	logic  free;
	logic  load;
	dec_t  dec;

	assign load = valid_s1 && free;

	pt5_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.words    (words),
		.take     (free),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	pt5_unpack u_unpack (
		.clk     (clk),
		.arst_n  (arst_n),
		.word_s1 (word_s1),
		.load    (load),
		.dec     (dec)
	);

	pt5_serializer u_serializer (
		.clk      (clk),
		.arst_n   (arst_n),
		.dec      (dec),
		.load_req (valid_s1),
		.free     (free),
		.chars    (chars)
	);
endmodule

// ----- src/pt5_in_reg.sv -----
// ---------------------------------------------------------------------------
// pt5_in_reg
// Input register stage: holds one accepted word until the decode can load it.
// ---------------------------------------------------------------------------
module pt5_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	pt5_word_if.sink       words,
	input  logic           take,
	output logic           valid_s1,
	output pt5_pkg::word_t word_s1
);
	import pt5_pkg::*;

	logic accept;

	assign words.ready = !valid_s1 || take;
	assign accept      = words.valid && words.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= words.packed_word;
		end
	end
endmodule

// ----- src/pt5_unpack.sv -----
// ---------------------------------------------------------------------------
// pt5_unpack
// Splits a word into its three codes, applies set toggles, builds the compacted
// character list and a terminator for an end word. Owns the character set bit.
// ---------------------------------------------------------------------------
module pt5_unpack (
	input  logic           clk,
	input  logic           arst_n,
	input  pt5_pkg::word_t word_s1,
	input  logic           load,
	output pt5_pkg::dec_t  dec
);
	import pt5_pkg::*;

	logic        char_set_q;
	code_t [2:0] code;
	logic  [2:0] tog;
	logic  [2:0] set;
	logic        set_next;
	logic        end_flag;

	assign end_flag = word_s1[WordW-1];

	always_comb begin
		cnt_t n;
		n = '0;
		dec.ent = '0;
		for (int i = 0; i < 3; i++) begin
			code[i] = word_s1[i*CodeW +: CodeW];
			tog[i]  = (code[i] == CodeToggle);
		end
		set[0] = char_set_q;
		set[1] = set[0] ^ tog[0];
		set[2] = set[1] ^ tog[1];
		set_next = end_flag ? 1'b0 : (set[2] ^ tog[2]);
		for (int i = 0; i < 3; i++) begin
			if (!tog[i]) begin
				dec.ent[n[1:0]] = '{character: lookup(set[i], code[i]), last: 1'b0};
				n = n + cnt_t'(1);
			end
		end
		// terminator after the characters of an end word
		if (end_flag) begin
			dec.ent[n[1:0]] = '{character: '0, last: 1'b1};
			n = n + cnt_t'(1);
		end
		dec.cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_set_q <= 1'b0;
		end else if (load) begin
			char_set_q <= set_next;
		end
	end
endmodule

// ----- src/pt5_serializer.sv -----
// ---------------------------------------------------------------------------
// pt5_serializer
// Result register: holds the characters of one word, hands them out one per
// cycle while ready; reloads when empty or in the cycle its last character is taken.
// ---------------------------------------------------------------------------
module pt5_serializer (
	input  logic          clk,
	input  logic          arst_n,
	input  pt5_pkg::dec_t dec,
	input  logic          load_req,
	output logic          free,
	pt5_char_if.source    chars
);
	import pt5_pkg::*;

	res_t [MaxRes-1:0] ent_q;
	cnt_t              rem_q;
	logic              load;
	logic              take;

	assign take  = chars.valid && chars.ready;
	assign free  = (rem_q == '0) || ((rem_q == cnt_t'(1)) && chars.ready);
	assign load  = load_req && free;

	assign chars.valid     = (rem_q != '0);
	assign chars.character = ent_q[0].character;
	assign chars.last      = ent_q[0].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= dec.cnt;
		end else if (take) begin
			rem_q <= rem_q - cnt_t'(1);
		end
	end

	// advance the list by one entry per taken character
	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= dec.ent;
		end else if (take) begin
			ent_q <= {res_t'('0), ent_q[MaxRes-1:1]};
		end
	end
endmodule

// ----- src/pt5_checker.sv -----
// ---------------------------------------------------------------------------
// pt5_checker
// Port-level checks on the decoder output stream.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pt5_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic                   out_ready,
	input pt5_pkg::char_t         out_character,
	input logic                   out_last
);
	import pt5_pkg::*;

	logic             stall_v;
	logic [CharW:0]   out_bus;

	assign stall_v = out_valid && !out_ready;
	assign out_bus = {out_last, out_character};

	// a terminator always carries the zero character
	`PT5_ASSERT_ALWAYS(a_last_is_zero, clk, (out_valid && out_last) |-> (out_character == '0))
	// decoded characters are never zero
	`PT5_ASSERT_ALWAYS(a_char_nonzero, clk, (out_valid && !out_last) |-> (out_character != '0))
	// a stalled character holds
	`PT5_ASSERT_RST(a_stall_hold, clk, arst_n, stall_v |=> (out_valid && $stable(out_bus)))
endmodule

bind packed_5bit_text_decoder pt5_checker u_pt5_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (chars.valid),
	.out_ready     (chars.ready),
	.out_character (chars.character),
	.out_last      (chars.last)
);
